[hw/rtl/shpc_pkg.sv]
// Shared types, codes and constants of the sized handle pool cache.
`default_nettype none
package shpc_pkg;

    localparam int DEF_CAPACITY = 16;

    localparam int HANDLE_W = 32;
    localparam int DIM_W    = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int MAXE_W   = 5;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 40;

    localparam logic [MAXE_W-1:0] MAX_ENTRIES_RST = 5'd16;
    localparam logic              MATCH_DIMS_RST  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_DIMS  = 2'd1;

    localparam logic [STATUS_W-1:0] STS_HIT         = 3'd0;
    localparam logic [STATUS_W-1:0] STS_MISS        = 3'd1;
    localparam logic [STATUS_W-1:0] STS_STORED      = 3'd2;
    localparam logic [STATUS_W-1:0] STS_EVICTED     = 3'd3;
    localparam logic [STATUS_W-1:0] STS_REJECTED    = 3'd4;
    localparam logic [STATUS_W-1:0] STS_CLR_HANDLE  = 3'd5;
    localparam logic [STATUS_W-1:0] STS_CLR_EMPTY   = 3'd6;

    typedef enum logic [OP_W-1:0] {
        OP_GET   = 2'd0,
        OP_PUT   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_EVICT,
        S_SHIFT,
        S_APPEND,
        S_CLR_RD,
        S_CLR_EMIT,
        S_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic [DIM_W-1:0]    height;
        logic [DIM_W-1:0]    width;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    typedef struct packed {
        logic                last;
        logic [COUNT_W-1:0]  count;
        logic [HANDLE_W-1:0] handle;
        logic [STATUS_W-1:0] status;
    } res_t;

    typedef struct packed {
        logic [MAXE_W-1:0] max_entries;
        logic              match_dims;
    } cfg_t;

endpackage
`default_nettype wire

[hw/rtl/shpc_store.sv]
// Entry memory: one write port, one read port, registered read data.
`default_nettype none
module shpc_store #(
    parameter int DEPTH = shpc_pkg::DEF_CAPACITY,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire shpc_pkg::entry_t wr_data,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_addr,
    output shpc_pkg::entry_t     rd_data
);
    import shpc_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[hw/rtl/shpc_ctrl.sv]
// Operation sequencer: search, shift, append and clear walks over the entry memory.
`default_nettype none
module shpc_ctrl #(
    parameter int CAPACITY = shpc_pkg::DEF_CAPACITY
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire shpc_pkg::cfg_t    cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire shpc_pkg::op_t     in_op,
    input  wire shpc_pkg::entry_t  in_entry,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output shpc_pkg::res_t         res
);
    import shpc_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > MAXE_W) ? CW : MAXE_W;

    ctrl_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    op_t           op_reg, op_next;
    entry_t        in_reg, in_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [HANDLE_W-1:0] res_handle_reg, res_handle_next;

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    entry_t        mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    entry_t        rd_data;

    logic [LW-1:0] limit;
    logic [LW-1:0] me_ext;
    logic [LW-1:0] count_ext;
    logic [LW-1:0] count_m1_ext;
    logic [CW-1:0] count_m1;
    logic          hit;
    logic          ptr_at_top;
    logic          ptr_zero;
    logic          put_room;

    shpc_store #(
        .DEPTH(CAPACITY),
        .AW   (AW)
    ) u_store (
        .clk    (clk),
        .wr_en  (mem_wr_en),
        .wr_addr(mem_wr_addr),
        .wr_data(mem_wr_data),
        .rd_en  (mem_rd_en),
        .rd_addr(mem_rd_addr),
        .rd_data(rd_data)
    );

    // A limit above capacity acts as capacity.
    assign me_ext       = LW'(cfg.max_entries);
    assign limit        = (me_ext > LW'(CAPACITY)) ? LW'(CAPACITY) : me_ext;
    assign count_ext    = LW'(count_reg);
    assign count_m1     = count_reg - CW'(1);
    assign count_m1_ext = LW'(count_m1);
    assign put_room     = count_ext < limit;
    assign hit          = !cfg.match_dims
                          || (rd_data.width == in_reg.width && rd_data.height == in_reg.height);
    assign ptr_at_top   = (CW'(ptr_reg) == count_m1);
    assign ptr_zero     = (ptr_reg == '0);

    // Next state and register updates
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        op_next         = op_reg;
        in_next         = in_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = in_op;
                    in_next = in_entry;
                    case (in_op)
                        OP_GET:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STS_MISS;
                                res_handle_next = '0;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                ptr_next   = count_m1[AW-1:0];
                                state_next = S_SEARCH;
                            end
                        end
                        OP_PUT:
                        begin
                            if (limit == '0)
                            begin
                                res_status_next = STS_REJECTED;
                                res_handle_next = in_entry.handle;
                                state_next      = S_EMIT;
                            end
                            else if (put_room)
                            begin
                                count_next      = count_reg + CW'(1);
                                res_status_next = STS_STORED;
                                res_handle_next = '0;
                                state_next      = S_EMIT;
                            end
                            else if (cfg.match_dims)
                            begin
                                state_next = S_EVICT;
                            end
                            else
                            begin
                                res_status_next = STS_REJECTED;
                                res_handle_next = in_entry.handle;
                                state_next      = S_EMIT;
                            end
                        end
                        OP_CLEAR:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STS_CLR_EMPTY;
                                res_handle_next = '0;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_CLR_RD;
                            end
                        end
                        OP_NONE:
                        begin
                            state_next = S_IDLE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                // rd_data holds the entry at ptr_reg, walking newest to oldest
                if (hit)
                begin
                    res_status_next = STS_HIT;
                    res_handle_next = rd_data.handle;
                    if (ptr_at_top)
                    begin
                        count_next = count_m1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + AW'(1);
                        state_next = S_SHIFT;
                    end
                end
                else if (ptr_zero)
                begin
                    res_status_next = STS_MISS;
                    res_handle_next = '0;
                    state_next      = S_EMIT;
                end
                else
                begin
                    ptr_next = ptr_reg - AW'(1);
                end
            end
            S_EVICT:
            begin
                res_status_next = STS_EVICTED;
                res_handle_next = rd_data.handle;
                if (count_reg == CW'(1))
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    ptr_next   = AW'(1);
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (ptr_at_top)
                begin
                    if (op_reg == OP_PUT)
                    begin
                        state_next = S_APPEND;
                    end
                    else
                    begin
                        count_next = count_m1;
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            S_APPEND:
            begin
                state_next = S_EMIT;
            end
            S_CLR_RD:
            begin
                state_next = S_CLR_EMIT;
            end
            S_CLR_EMIT:
            begin
                if (res_ready)
                begin
                    count_next = count_m1;
                    if (count_reg == CW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + AW'(1);
                        state_next = S_CLR_RD;
                    end
                end
            end
            S_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory control and result outputs
    always_comb
    begin
        in_ready    = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = in_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        res_valid   = 1'b0;
        res.status  = res_status_reg;
        res.handle  = res_handle_reg;
        res.count   = count_ext[COUNT_W-1:0];
        res.last    = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_op)
                        OP_GET:
                        begin
                            mem_rd_en   = (count_reg != '0);
                            mem_rd_addr = count_m1[AW-1:0];
                        end
                        OP_PUT:
                        begin
                            if (limit != '0 && put_room)
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = count_reg[AW-1:0];
                                mem_wr_data = in_entry;
                            end
                            else if (limit != '0 && cfg.match_dims)
                            begin
                                // oldest entry leaves
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = '0;
                            end
                        end
                        OP_CLEAR:
                        begin
                            mem_rd_en = 1'b0;
                        end
                        OP_NONE:
                        begin
                            mem_rd_en = 1'b0;
                        end
                        default:
                        begin
                            mem_rd_en = 1'b0;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (hit)
                begin
                    mem_rd_en   = !ptr_at_top;
                    mem_rd_addr = ptr_reg + AW'(1);
                end
                else
                begin
                    mem_rd_en   = !ptr_zero;
                    mem_rd_addr = ptr_reg - AW'(1);
                end
            end
            S_EVICT:
            begin
                mem_rd_en   = (count_reg != CW'(1));
                mem_rd_addr = AW'(1);
            end
            S_SHIFT:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = ptr_reg - AW'(1);
                mem_wr_data = rd_data;
                mem_rd_en   = !ptr_at_top;
                mem_rd_addr = ptr_reg + AW'(1);
            end
            S_APPEND:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = count_m1[AW-1:0];
                mem_wr_data = in_reg;
            end
            S_CLR_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = ptr_reg;
            end
            S_CLR_EMIT:
            begin
                res_valid  = 1'b1;
                res.status = STS_CLR_HANDLE;
                res.handle = rd_data.handle;
                res.count  = count_m1_ext[COUNT_W-1:0];
                res.last   = (count_reg == CW'(1));
            end
            S_EMIT:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            op_reg    <= OP_NONE;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            op_reg    <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg         <= in_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_no_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && mem_rd_en && mem_wr_addr == mem_rd_addr))
        else $error("read and write hit the same entry in one cycle");

    // clear walks the pointer up while the count falls, so only search and shift are bounded
    a_ptr_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH || state_reg == S_SHIFT) |-> (CW'(ptr_reg) < count_reg))
        else $error("walk pointer outside the held entries");

    a_shift_not_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> !ptr_zero)
        else $error("shift source at entry zero");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("result dropped while stalled");

endmodule
`default_nettype wire

[hw/rtl/sized_handle_pool_cache_top.sv]
// Top level of the sized handle pool cache: config registers, sequencer, output register.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  tuser op, tdata handle/width/height
//  m_*       out        m_tvalid / m_tready  tdata status/out_handle/count, tlast
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Put that stores, reject, miss on empty, clear of empty: a result with no memory walk.
// Get: a search of entries newest to oldest, then the entries above the hit, shifted down one a cycle.
// Put with eviction: oldest read, shift, append. Clear: one read and one result per entry.
// The one-read, one-write entry memory and its registered read set these steps.
// rst_n clears the count and sets the config registers to their reset values; entry memory is not cleared.
// A stalled m_tready holds the sequencer; the next input beat is taken once the
// last result sits in the output register.
`default_nettype none
module sized_handle_pool_cache_top #(
    parameter int CAPACITY = shpc_pkg::DEF_CAPACITY
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // config write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [shpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [shpc_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [shpc_pkg::IN_TDATA_W-1:0]    s_tdata,  // handle[31:0], width, height
    input  wire logic [shpc_pkg::OP_W-1:0]          s_tuser,  // op
    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [shpc_pkg::OUT_TDATA_W-1:0]        m_tdata,  // status[2:0], out_handle, count
    output logic                                    m_tlast
);
    import shpc_pkg::*;

    logic [MAXE_W-1:0] max_entries_reg, max_entries_next;
    logic              match_dims_reg, match_dims_next;
    logic              m_tvalid_reg, m_tvalid_next;
    res_t              out_reg, out_next;

    cfg_t   cfg;
    entry_t in_entry;
    logic   res_valid;
    logic   res_ready;
    res_t   res;

    assign cfg.max_entries = max_entries_reg;
    assign cfg.match_dims  = match_dims_reg;
    assign cfg_ready       = 1'b1;

    assign in_entry.handle = s_tdata[HANDLE_W-1:0];
    assign in_entry.width  = s_tdata[HANDLE_W+DIM_W-1:HANDLE_W];
    assign in_entry.height = s_tdata[HANDLE_W+2*DIM_W-1:HANDLE_W+DIM_W];

    shpc_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (op_t'(s_tuser)),
        .in_entry (in_entry),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    always_comb
    begin
        max_entries_next = max_entries_reg;
        match_dims_next  = match_dims_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_MAX_ENTRIES:
                begin
                    max_entries_next = cfg_data[MAXE_W-1:0];
                end
                REG_MATCH_DIMS:
                begin
                    match_dims_next = cfg_data[0];
                end
                default:
                begin
                    max_entries_next = max_entries_reg;
                end
            endcase
        end
    end

    // output register: loads when empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (res_ready)
        begin
            m_tvalid_next = res_valid;
            out_next      = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= MAX_ENTRIES_RST;
            match_dims_reg  <= MATCH_DIMS_RST;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            max_entries_reg <= max_entries_next;
            match_dims_reg  <= match_dims_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.count, out_reg.handle, out_reg.status};
    assign m_tlast  = out_reg.last;

endmodule
`default_nettype wire
